// ===== rtl/core/r50_pkg.sv =====
// shared constants and helpers for the radix-50 codec
`default_nettype none
package r50_pkg;

  localparam int unsigned DigitW = 6;
  localparam int unsigned CharW  = 8;
  localparam int unsigned WordW  = 16;

  localparam logic [WordW-1:0] Base   = 16'd40;
  localparam logic [WordW-1:0] Limit  = 16'd64000;
  // x * Recip5 >> Recip5Sh equals x / 5 for any 16-bit x
  localparam logic [15:0]      Recip5   = 16'd52429;
  localparam int unsigned      Recip5Sh = 18;

  localparam logic [DigitW-1:0] DigSpace  = 6'd0;
  localparam logic [DigitW-1:0] DigLetA   = 6'd1;
  localparam logic [DigitW-1:0] DigLetZ   = 6'd26;
  localparam logic [DigitW-1:0] DigDollar = 6'd27;
  localparam logic [DigitW-1:0] DigDot    = 6'd28;
  localparam logic [DigitW-1:0] DigHigh   = 6'd29;
  localparam logic [DigitW-1:0] DigNum0   = 6'd30;
  localparam logic [DigitW-1:0] DigNum9   = 6'd39;

  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChDollar = 8'h24;
  localparam logic [CharW-1:0] ChDot    = 8'h2e;
  localparam logic [CharW-1:0] ChHigh   = 8'hff;
  localparam logic [CharW-1:0] ChNum0   = 8'h30;
  localparam logic [CharW-1:0] ChNum9   = 8'h39;
  localparam logic [CharW-1:0] ChLowA   = 8'h61;
  localparam logic [CharW-1:0] ChLowZ   = 8'h7a;
  localparam logic [CharW-1:0] ChUpA    = 8'h41;
  localparam logic [CharW-1:0] ChUpZ    = 8'h5a;
  localparam logic [CharW-1:0] CaseBit  = 8'h20;

  // digit value to character
  function automatic logic [CharW-1:0] alpha_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    c = '0;
    if (d == DigSpace) begin
      c = ChSpace;
    end else if (d >= DigLetA && d <= DigLetZ) begin
      c = ChLowA + CharW'(d - DigLetA);
    end else if (d == DigDollar) begin
      c = ChDollar;
    end else if (d == DigDot) begin
      c = ChDot;
    end else if (d == DigHigh) begin
      c = ChHigh;
    end else if (d >= DigNum0 && d <= DigNum9) begin
      c = ChNum0 + CharW'(d - DigNum0);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/r50_char_digit.sv =====
// character to radix-50 digit mapping with end-of-string and bad detection
`default_nettype none
module r50_char_digit (
  input  logic [7:0] ch_i,
  output logic [5:0] digit_o,
  output logic       nul_o,
  output logic       bad_o
);

  logic [7:0] low;

  always_comb begin
    low = ch_i;
    if (ch_i inside {[r50_pkg::ChUpA:r50_pkg::ChUpZ]}) begin
      low = ch_i | r50_pkg::CaseBit;
    end
  end

  always_comb begin
    digit_o = r50_pkg::DigSpace;
    bad_o   = 1'b0;
    if (low == r50_pkg::ChSpace) begin
      digit_o = r50_pkg::DigSpace;
    end else if (low inside {[r50_pkg::ChLowA:r50_pkg::ChLowZ]}) begin
      digit_o = r50_pkg::DigLetA + 6'(low - r50_pkg::ChLowA);
    end else if (low == r50_pkg::ChDollar) begin
      digit_o = r50_pkg::DigDollar;
    end else if (low == r50_pkg::ChDot) begin
      digit_o = r50_pkg::DigDot;
    end else if (low == r50_pkg::ChHigh) begin
      digit_o = r50_pkg::DigHigh;
    end else if (low inside {[r50_pkg::ChNum0:r50_pkg::ChNum9]}) begin
      digit_o = r50_pkg::DigNum0 + 6'(low - r50_pkg::ChNum0);
    end else begin
      bad_o = 1'b1;
    end
  end

  assign nul_o = (ch_i == '0);

endmodule
`default_nettype wire

// ===== rtl/core/radix50_codec.sv =====
// radix-50 three-character encoder and word decoder, four-stage pipeline
//
//  channel | handshake                 | payload
//  in      | in_valid_i / in_ready_o   | kind_i, char_*_i, packed_in_i
//  out     | out_valid_o / out_ready_i | packed_out_o, out_*_o, bad_symbol_o
//
// one transaction per cycle while the output is not stalled
// stage 1 maps characters to digits and forms the first divide-by-40 product,
// stage 2 forms the first remainder and second product, stage 3 the top two
// digits or the packed word, stage 4 looks up the characters into the output
// each stage holds when it is full and the stage after it is full and stalled
// reset empties all stages; payload registers are not reset
`default_nettype none
module radix50_codec (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  char_first_i,
  input  logic [7:0]  char_second_i,
  input  logic [7:0]  char_third_i,
  input  logic [15:0] packed_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] packed_out_o,
  output logic [7:0]  out_first_o,
  output logic [7:0]  out_second_o,
  output logic [7:0]  out_third_o,
  output logic        bad_symbol_o
);

  logic [3:0] vld_q;
  logic [3:0] adv;

  assign adv[3] = !vld_q[3] || out_ready_i;
  assign adv[2] = !vld_q[2] || adv[3];
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
    end
  end

  // stage 1: digit mapping and first reciprocal product
  logic [5:0] dig0, dig1, dig2;
  logic       nul0, nul1, nul2;
  logic       bad0, bad1, bad2;
  logic       end1, end2;

  r50_char_digit u_dig0 (.ch_i(char_first_i),  .digit_o(dig0), .nul_o(nul0), .bad_o(bad0));
  r50_char_digit u_dig1 (.ch_i(char_second_i), .digit_o(dig1), .nul_o(nul1), .bad_o(bad1));
  r50_char_digit u_dig2 (.ch_i(char_third_i),  .digit_o(dig2), .nul_o(nul2), .bad_o(bad2));

  // a nul ends the string for its own and every later position
  assign end1 = nul0 || nul1;
  assign end2 = end1 || nul2;

  logic        s1_kind_q;
  logic [15:0] s1_word_q;
  logic        s1_over_q;
  logic        s1_bad_q;
  logic [5:0]  s1_d0_q, s1_d1_q, s1_d2_q;
  logic [28:0] s1_prod_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_kind_q <= kind_i;
      s1_word_q <= packed_in_i;
      s1_over_q <= (packed_in_i >= r50_pkg::Limit);
      s1_bad_q  <= (!nul0 && bad0) || (!end1 && bad1) || (!end2 && bad2);
      s1_d0_q   <= (nul0 || bad0) ? r50_pkg::DigSpace : dig0;
      s1_d1_q   <= (end1 || bad1) ? r50_pkg::DigSpace : dig1;
      s1_d2_q   <= (end2 || bad2) ? r50_pkg::DigSpace : dig2;
      // (word / 8) / 5 gives word / 40
      s1_prod_q <= 29'(packed_in_i[15:3]) * 29'(r50_pkg::Recip5);
    end
  end

  // stage 2: low digit of the word, second product, first encode step
  logic [10:0] s2_quo;
  logic [15:0] s2_rem_w;

  assign s2_quo   = s1_prod_q[r50_pkg::Recip5Sh +: 11];
  assign s2_rem_w = s1_word_q - ({5'b0, s2_quo} * r50_pkg::Base);

  logic        s2_kind_q;
  logic        s2_over_q;
  logic        s2_bad_q;
  logic [10:0] s2_quo_q;
  logic [5:0]  s2_r2_q;
  logic [23:0] s2_prod_q;
  logic [10:0] s2_acc_q;
  logic [5:0]  s2_d2_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_kind_q <= s1_kind_q;
      s2_over_q <= s1_over_q;
      s2_bad_q  <= s1_bad_q;
      s2_quo_q  <= s2_quo;
      s2_r2_q   <= s2_rem_w[5:0];
      s2_prod_q <= 24'(s2_quo[10:3]) * 24'(r50_pkg::Recip5);
      s2_acc_q  <= 11'(s1_d0_q) * 11'(r50_pkg::Base) + 11'(s1_d1_q);
      s2_d2_q   <= s1_d2_q;
    end
  end

  // stage 3: top two digits of the word, packed word
  logic [5:0]  s3_q0;
  logic [10:0] s3_rem_w;

  assign s3_q0    = s2_prod_q[r50_pkg::Recip5Sh +: 6];
  assign s3_rem_w = s2_quo_q - (11'(s3_q0) * 11'(r50_pkg::Base));

  logic        s3_kind_q;
  logic        s3_over_q;
  logic        s3_bad_q;
  logic [5:0]  s3_q0_q, s3_r1_q, s3_r2_q;
  logic [15:0] s3_word_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_kind_q <= s2_kind_q;
      s3_over_q <= s2_over_q;
      s3_bad_q  <= s2_bad_q;
      s3_q0_q   <= s3_q0;
      s3_r1_q   <= s3_rem_w[5:0];
      s3_r2_q   <= s2_r2_q;
      s3_word_q <= 16'(s2_acc_q) * r50_pkg::Base + 16'(s2_d2_q);
    end
  end

  // stage 4: alphabet lookup into the output register
  logic        dec_ok;

  assign dec_ok = s3_kind_q && !s3_over_q;

  logic [15:0] out_word_q;
  logic [7:0]  out_c0_q, out_c1_q, out_c2_q;
  logic        out_bad_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      out_word_q <= s3_kind_q ? '0 : s3_word_q;
      out_c0_q   <= dec_ok ? r50_pkg::alpha_char(s3_q0_q) : '0;
      out_c1_q   <= dec_ok ? r50_pkg::alpha_char(s3_r1_q) : '0;
      out_c2_q   <= dec_ok ? r50_pkg::alpha_char(s3_r2_q) : '0;
      out_bad_q  <= s3_kind_q ? s3_over_q : s3_bad_q;
    end
  end

  assign out_valid_o  = vld_q[3];
  assign packed_out_o = out_word_q;
  assign out_first_o  = out_c0_q;
  assign out_second_o = out_c1_q;
  assign out_third_o  = out_c2_q;
  assign bad_symbol_o = out_bad_q;

endmodule
`default_nettype wire
